// File: rtl/trdd_pkg.sv
// Package with the shared types, constants and status codes of the tag read table.
package trdd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MILLIS_MOD = 1000;
    // Ceiling of 2^38 / 1000: bits 38 and up of a 32-bit value times this give value / 1000.
    localparam logic [31:0] MILLIS_RECIP = 32'h10624DD3;
    localparam logic [31:0] AGING_RESET = 32'd10;

    typedef enum logic [2:0] {
        ST_ADDED  = 3'd0,
        ST_REREAD = 3'd1,
        ST_FULL   = 3'd2,
        ST_ZERO   = 3'd3,
        ST_RECORD = 3'd4,
        ST_EMPTY  = 3'd5
    } t_status;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic {
        REG_FIX   = 1'b0,
        REG_AGING = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_ADD_RD,
        S_ADD_CK,
        S_ADD_FIN,
        S_FL_RD,
        S_FL_CK,
        S_FL_FIN
    } t_state;

    typedef struct packed {
        logic [31:0]        code;
        logic signed [7:0]  strength;
        logic [15:0]        antenna;
        logic [31:0]        seconds;
        logic [9:0]         millis;
        logic [31:0]        reads;
    } t_entry;

    typedef struct packed {
        logic               last;
        t_status            status;
        logic [5:0]         slot;
        logic [31:0]        code;
        logic signed [7:0]  strength;
        logic [31:0]        reads;
        logic [31:0]        seconds;
        logic [9:0]         millis;
        logic [15:0]        antenna;
        logic [31:0]        log_id;
        logic [31:0]        total;
    } t_result;

endpackage

// File: rtl/trdd_ram.sv
// Generic single write, single read RAM with a registered read port.
module trdd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/trdd_mod1000.sv
// Remainder unit that reduces a 32-bit millisecond count modulo 1000.
module trdd_mod1000 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [9:0]  o_rem
);
    import trdd_pkg::*;

    logic [31:0] r_val, n_val;
    logic [22:0] r_quo, n_quo;
    logic [9:0]  r_rem, n_rem;
    logic [1:0]  r_cnt, n_cnt;
    logic [63:0] product;
    logic [31:0] back;

    // First the quotient by reciprocal multiplication, then the value minus quotient times 1000.
    always_comb begin
        product = {32'd0, r_val} * {32'd0, MILLIS_RECIP};
        back    = 32'(r_quo) * 32'(MILLIS_MOD);
        n_val   = r_val;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_val = i_value;
            n_cnt = 2'd2;
        end else if (r_cnt == 2'd2) begin
            // The quotient never exceeds 23 bits for a 32-bit value.
            n_quo = product[60:38];
            n_cnt = 2'd1;
        end else if (r_cnt == 2'd1) begin
            n_rem = 10'(r_val - back);
            n_cnt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rem <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_rem <= n_rem;
        end
        r_val <= n_val;
        r_quo <= n_quo;
    end

    assign o_done = (r_cnt == 2'd0) && !i_start;
    assign o_rem  = r_rem;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < 10'(MILLIS_MOD)) else $error("remainder out of range");
endmodule

// File: rtl/tag_read_dedup_table.sv
// One word at a time: no new word is taken until the last one is finished. The slot scan
// reads the entry RAM slot by slot, each slot in a read state (address) and a check state
// (registered data); adds and flushes may stall on the output, and a zero code is answered
// without a slot scan.
// Reset (synchronous, active low) empties every slot through the valid bits at once,
// clears the added-tag total and loads the registers with fix off and ten seconds of aging.
module tag_read_dedup_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    // Input words.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // tdata from bit 0: tag_code 32, strength 8, antenna 16, read_seconds 32,
    // read_millis_raw 32, flush_time 32, max_records 7, first_log_id 32, one pad bit.
    input  logic [191:0]  i_s_tdata,
    // tuser: op.
    input  logic          i_s_tuser,
    // Result words.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // tdata from bit 0: slot_index 6, record_code 32, record_strength 8, record_reads 32,
    // record_seconds 32, record_millis 10, record_antenna 16, record_log_id 32,
    // new_tag_total 32.
    output logic [199:0]  o_m_tdata,
    // tuser: status.
    output logic [2:0]    o_m_tuser,
    output logic          o_m_tlast
);
    import trdd_pkg::*;

    // Configuration registers.
    logic        r_fix;
    logic [31:0] r_aging;

    // Latched input word.
    logic [31:0]        r_code;
    logic signed [7:0]  r_str;
    logic [15:0]        r_ant;
    logic [31:0]        r_sec;
    logic [31:0]        r_now;
    logic [6:0]         r_maxr;
    logic [31:0]        r_log;

    // Sequencer state.
    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [31:0]        r_count, n_count;
    logic               r_hit, n_hit;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    t_entry             r_hit_word, n_hit_word;
    logic               r_emp, n_emp;
    logic [IDX_W-1:0]   r_emp_idx, n_emp_idx;
    logic [6:0]         r_n, n_n;
    logic               r_pend, n_pend;
    t_result            r_pend_res, n_pend_res;
    logic [31:0]        r_next_log, n_next_log;

    // Output register.
    logic               r_out_v, n_out_v;
    t_result            r_out, n_out;

    // RAM and remainder unit.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata, ram_rdata;
    logic               mod_start, mod_done;
    logic [9:0]         mod_rem;

    logic               in_acc, out_free, last_slot, aged, upd;
    logic [31:0]        due;
    t_result            res;

    trdd_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    trdd_mod1000 u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_s_tdata[119:88]),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_v || i_m_tready;
    assign last_slot  = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign due        = ram_rdata.seconds + r_aging;
    assign aged       = r_valid[r_idx] && (due <= r_now) && (r_n < r_maxr);
    assign mod_start  = in_acc && (t_op'(i_s_tuser) == OP_ADD);
    // A stronger reread replaces strength, antenna and time only with fix mode on.
    assign upd        = r_fix && (r_str > r_hit_word.strength);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix   <= 1'b0;
            r_aging <= AGING_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FIX:   r_fix   <= i_cfg_data[0];
                REG_AGING: r_aging <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_s_tdata[31:0];
            r_str  <= i_s_tdata[39:32];
            r_ant  <= i_s_tdata[55:40];
            r_sec  <= i_s_tdata[87:56];
            r_now  <= i_s_tdata[151:120];
            r_maxr <= i_s_tdata[158:152];
            r_log  <= i_s_tdata[190:159];
        end
    end

    // Sequencer: slot by slot through a read and a check state, the output register decoupling the result side.
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_valid    = r_valid;
        n_count    = r_count;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_word = r_hit_word;
        n_emp      = r_emp;
        n_emp_idx  = r_emp_idx;
        n_n        = r_n;
        n_pend     = r_pend;
        n_pend_res = r_pend_res;
        n_next_log = r_next_log;
        n_out_v    = r_out_v && !i_m_tready;
        n_out      = r_out;
        ram_we     = 1'b0;
        ram_waddr  = r_hit_idx;
        ram_wdata  = r_hit_word;
        res        = '0;
        res.total  = r_count;
        res.last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_emp   = 1'b0;
                    n_n     = '0;
                    n_pend  = 1'b0;
                    n_next_log = i_s_tdata[190:159];
                    if (t_op'(i_s_tuser) == OP_FLUSH) begin
                        n_state = S_FL_RD;
                    end else if (i_s_tdata[31:0] == 32'd0) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_ADD_RD;
                    end
                end
            end
            S_ZERO: begin
                if (out_free) begin
                    res.status = ST_ZERO;
                    n_out   = res;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ADD_RD: n_state = S_ADD_CK;
            S_ADD_CK: begin
                if (!r_hit && r_valid[r_idx] && ram_rdata.code == r_code) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_word = ram_rdata;
                end
                if (!r_emp && !r_valid[r_idx]) begin
                    n_emp     = 1'b1;
                    n_emp_idx = r_idx;
                end
                if (last_slot) begin
                    n_state = S_ADD_FIN;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_ADD_RD;
                end
            end
            S_ADD_FIN: begin
                if (out_free && mod_done) begin
                    if (r_hit) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_hit_idx;
                        ram_wdata = r_hit_word;
                        ram_wdata.reads = r_hit_word.reads + 32'd1;
                        if (upd) begin
                            ram_wdata.strength = r_str;
                            ram_wdata.antenna  = r_ant;
                            ram_wdata.seconds  = r_sec;
                            ram_wdata.millis   = mod_rem;
                        end
                        res.status = ST_REREAD;
                        res.slot   = 6'(r_hit_idx);
                    end else if (r_emp) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_emp_idx;
                        ram_wdata.code     = r_code;
                        ram_wdata.strength = r_str;
                        ram_wdata.antenna  = r_ant;
                        ram_wdata.seconds  = r_sec;
                        ram_wdata.millis   = mod_rem;
                        ram_wdata.reads    = 32'd1;
                        n_valid[r_emp_idx] = 1'b1;
                        n_count    = r_count + 32'd1;
                        res.status = ST_ADDED;
                        res.slot   = 6'(r_emp_idx);
                        res.total  = r_count + 32'd1;
                    end else begin
                        res.status = ST_FULL;
                    end
                    n_out   = res;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FL_RD: n_state = S_FL_CK;
            S_FL_CK: begin
                // An aged entry waits as pending until it is known whether another follows.
                if (aged && r_pend && !out_free) begin
                    n_state = S_FL_CK;
                end else begin
                    if (aged) begin
                        if (r_pend) begin
                            n_out = r_pend_res;
                            n_out.last = 1'b0;
                            n_out_v = 1'b1;
                        end
                        res.status   = ST_RECORD;
                        res.slot     = 6'(r_idx);
                        res.code     = ram_rdata.code;
                        res.strength = 8'(8'sd0 - ram_rdata.strength);
                        res.reads    = ram_rdata.reads;
                        res.seconds  = ram_rdata.seconds;
                        res.millis   = ram_rdata.millis;
                        res.antenna  = ram_rdata.antenna;
                        res.log_id   = r_next_log;
                        n_pend_res   = res;
                        n_pend       = 1'b1;
                        n_next_log   = r_next_log + 32'd1;
                        n_n          = r_n + 7'd1;
                        n_valid[r_idx] = 1'b0;
                    end
                    if (last_slot) begin
                        n_state = S_FL_FIN;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_FL_RD;
                    end
                end
            end
            S_FL_FIN: begin
                if (out_free) begin
                    if (r_pend) begin
                        n_out = r_pend_res;
                        n_out.last = 1'b1;
                    end else begin
                        res.status = ST_EMPTY;
                        n_out = res;
                    end
                    n_out_v = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_out_v <= 1'b0;
            r_pend  <= 1'b0;
            r_n     <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            r_out_v <= n_out_v;
            r_pend  <= n_pend;
            r_n     <= n_n;
            r_idx   <= n_idx;
        end
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_word <= n_hit_word;
        r_emp      <= n_emp;
        r_emp_idx  <= n_emp_idx;
        r_pend_res <= n_pend_res;
        r_next_log <= n_next_log;
        r_out      <= n_out;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {r_out.total, r_out.log_id, r_out.antenna, r_out.millis,
                         r_out.seconds, r_out.reads, r_out.strength, r_out.code,
                         r_out.slot};

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + 32'd1))
        else $error("added total moved by more than one");
    a_rec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FL_CK || r_state == S_FL_FIN) |-> (r_n <= r_maxr))
        else $error("flush emitted more records than allowed");
    a_mod_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_FIN && n_state == S_IDLE) |-> mod_done)
        else $error("add completed before the remainder was ready");
    a_no_busy_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_tready)
        else $error("input taken while a word is in progress");
endmodule
